/* rtl/hbd_pkg.sv */
// Shared types and constants for the H-bridge drive controller.
package hbd_pkg;

  // Item kinds on the input stream
  typedef enum logic [1:0] {
    OP_DRIVE = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_DRIVE = 2'd0,
    REG_MAX_STEER = 2'd1,
    REG_TIMEOUT   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [15:0] drive_full_scale;
    logic [15:0] steer_full_scale;
    logic [31:0] timeout_ticks;
  } cfg_t;

  localparam int unsigned MUL_W = 30;

  localparam logic signed [10:0] CMD_MAX     = 11'sd1000;
  localparam logic signed [10:0] CMD_MIN     = -11'sd1000;
  localparam logic signed [10:0] DEADBAND    = 11'sd20;
  localparam logic signed [10:0] DIR_LIMIT   = 11'sd50;
  localparam logic signed [10:0] STEER_LIMIT = 11'sd80;
  localparam logic [6:0]         SPEED_MAX   = 7'd100;

  // x/3125 ~ (x*RECIP_3125) >> 40, x/125 ~ (x*RECIP_125) >> 32; both low by at most one
  localparam logic [28:0] RECIP_3125 = 29'd351843720;
  localparam logic [25:0] RECIP_125  = 26'd34359738;
  localparam logic [11:0] DIV_3125   = 12'd3125;
  localparam logic [6:0]  DIV_125    = 7'd125;
  localparam logic [8:0]  ROUND_HALF = 9'd500;

  localparam logic [3:0] LAST_STEP = 4'd9;

endpackage

/* rtl/hbd_mul.sv */
// Shared unsigned multiplier with a registered product.
module hbd_mul (
  input  logic                          clk_i,
  input  logic [hbd_pkg::MUL_W-1:0]     a_i,
  input  logic [hbd_pkg::MUL_W-1:0]     b_i,
  output logic [2*hbd_pkg::MUL_W-1:0]   p_o
);
  import hbd_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* rtl/hbd_regs.sv */
// APB configuration registers: duty full scales and watchdog timeout.
module hbd_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output hbd_pkg::cfg_t      cfg_o
);
  import hbd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_DRIVE: cfg_d.drive_full_scale = pwdata[15:0];
        REG_MAX_STEER: cfg_d.steer_full_scale = pwdata[15:0];
        REG_TIMEOUT:   cfg_d.timeout_ticks    = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_DRIVE: prdata = {16'd0, cfg_q.drive_full_scale};
      REG_MAX_STEER: prdata = {16'd0, cfg_q.steer_full_scale};
      REG_TIMEOUT:   prdata = cfg_q.timeout_ticks;
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_full_scale <= 16'd255;
      cfg_q.steer_full_scale <= 16'd255;
      cfg_q.timeout_ticks    <= 32'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/hbridge_drive_with_command_watchdog.sv */
// Top level: command state, watchdog, multiply sequencer and output register.
//
// Input stream (s_axis_*): one word per item; tuser carries the kind (drive,
// stop, tick), tdata the steer, throttle and speed of a drive command.
// Output stream (m_axis_*): one word per input item with bridge pins, PWM
// duties and status flags.
// APB port: max drive duty (0x0), max steer duty (0x4), timeout ticks (0x8).
// An accepted word updates the held command and watchdog at once; the duties
// are then worked out in the ST_CALC steps on one shared 30x30 multiplier (products
// first, then reciprocal divides, then back-multiplies for the fix-up), and
// the result word goes into the output register from ST_DONE once it is free.
// s_axis_tready is low from accept until the result is loaded, so no new word
// is taken while one is still being worked on. If the receiver stalls, the
// finished result waits in the output register while the next word is
// accepted and worked on; that word's result then waits until the register
// is free.
// Reset clears the held command, arms the watchdog with zero elapsed ticks,
// clears the watchdog flag and loads the register defaults (255, 255, 500).
module hbridge_drive_with_command_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // steer_cmd, throttle_cmd, speed_cmd
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_fwd, drive_rev, drive_duty, steer_right, steer_left, steer_duty,
  // direction_class, steering_class, accel_pct, timed_out, watchdog_stopped
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hbd_pkg::*;

  cfg_t cfg;

  hbd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------- command state and watchdog
  logic signed [10:0] steer_in, thr_in;
  logic signed [10:0] steer_cl, thr_cl;
  logic [6:0]         speed_in, speed_cl;
  logic [1:0]         op_in;
  logic               in_acc;

  logic signed [10:0] hs_q, hs_d, ht_q, ht_d;
  logic [6:0]         hsp_q, hsp_d;
  logic [31:0]        el_q, el_d, el_inc;
  logic               armed_q, armed_d, fired_q, fired_d;

  assign op_in    = s_axis_tuser;
  assign steer_in = s_axis_tdata[10:0];
  assign thr_in   = s_axis_tdata[21:11];
  assign speed_in = s_axis_tdata[28:22];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  assign steer_cl = (steer_in > CMD_MAX) ? CMD_MAX : ((steer_in < CMD_MIN) ? CMD_MIN : steer_in);
  assign thr_cl   = (thr_in > CMD_MAX) ? CMD_MAX : ((thr_in < CMD_MIN) ? CMD_MIN : thr_in);
  assign speed_cl = (speed_in > SPEED_MAX) ? SPEED_MAX : speed_in;
  assign el_inc   = (el_q != '1) ? el_q + 32'd1 : el_q;

  always_comb begin
    hs_d = hs_q;
    ht_d = ht_q;
    hsp_d = hsp_q;
    el_d = el_q;
    armed_d = armed_q;
    fired_d = fired_q;
    if (in_acc) begin
      unique case (op_in)
        OP_DRIVE: begin
          hs_d = steer_cl;
          ht_d = thr_cl;
          hsp_d = speed_cl;
          el_d = '0;
          armed_d = 1'b1;
          fired_d = 1'b0;
        end
        OP_STOP: begin
          hs_d = '0;
          ht_d = '0;
          hsp_d = '0;
          el_d = '0;
          armed_d = 1'b1;
          fired_d = 1'b0;
        end
        OP_TICK: begin
          if (armed_q) begin
            el_d = el_inc;
            if (el_inc > cfg.timeout_ticks && !fired_q) begin
              hs_d = '0;
              ht_d = '0;
              hsp_d = '0;
              armed_d = 1'b0;
              fired_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= '0;
      ht_q <= '0;
      hsp_q <= '0;
      el_q <= '0;
      armed_q <= 1'b1;
      fired_q <= 1'b0;
    end else begin
      hs_q <= hs_d;
      ht_q <= ht_d;
      hsp_q <= hsp_d;
      el_q <= el_d;
      armed_q <= armed_d;
      fired_q <= fired_d;
    end
  end

  // ---------------- sequencer
  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_free, load_out;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CALC;
      ST_CALC: if (step_q == LAST_STEP) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    load_out      = (state_q == ST_DONE) && out_free;
    step_d        = (state_q == ST_CALC) ? step_q + 4'd1 : 4'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  // ---------------- shared multiplier and arithmetic registers
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [9:0]         at_mag, as_mag;
  logic [16:0]        p_q;    // |throttle| * speed
  logic [25:0]        s_q;    // |steer| * max steer duty
  logic [32:0]        q_q;    // p * max drive duty
  logic [15:0]        qs_q, qd_q;
  logic [6:0]         qa_q;
  logic [13:0]        ya;
  logic [22:0]        rs;
  logic [13:0]        ra;
  logic [27:0]        rd;
  logic [16:0]        p_rnd;

  assign at_mag = ht_q[10] ? 10'(-ht_q) : ht_q[9:0];
  assign as_mag = hs_q[10] ? 10'(-hs_q) : hs_q[9:0];
  assign p_rnd  = p_q + 17'(ROUND_HALF);
  assign ya     = p_rnd[16:3];

  hbd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_CALC) begin
      unique case (step_q)
        4'd0: begin mul_a = MUL_W'(at_mag);      mul_b = MUL_W'(hsp_q); end
        4'd1: begin mul_a = MUL_W'(as_mag);      mul_b = MUL_W'(cfg.steer_full_scale); end
        4'd2: begin mul_a = MUL_W'(p_q);         mul_b = MUL_W'(cfg.drive_full_scale); end
        4'd3: begin mul_a = MUL_W'(s_q[25:3]);   mul_b = MUL_W'(RECIP_125); end
        4'd4: begin mul_a = MUL_W'(ya);          mul_b = MUL_W'(RECIP_125); end
        4'd5: begin mul_a = MUL_W'(q_q[32:5]);   mul_b = MUL_W'(RECIP_3125); end
        4'd6: begin mul_a = MUL_W'(qs_q);        mul_b = MUL_W'(DIV_125); end
        4'd7: begin mul_a = MUL_W'(qa_q);        mul_b = MUL_W'(DIV_125); end
        4'd8: begin mul_a = MUL_W'(qd_q);        mul_b = MUL_W'(DIV_3125); end
        default: ;
      endcase
    end
  end

  // remainders for the one-step quotient fix-up
  assign rs = s_q[25:3] - prod[22:0];
  assign ra = ya - prod[13:0];
  assign rd = q_q[32:5] - prod[27:0];

  // each step from 1 on stores the product issued one step earlier, or the quotient fixed up by it
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      unique case (step_q)
        4'd1: p_q <= prod[16:0];
        4'd2: s_q <= prod[25:0];
        4'd3: q_q <= prod[32:0];
        4'd4: qs_q <= prod[47:32];
        4'd5: qa_q <= prod[38:32];
        4'd6: qd_q <= prod[55:40];
        4'd7: if (rs >= 23'(DIV_125)) qs_q <= qs_q + 16'd1;
        4'd8: if (ra >= 14'(DIV_125)) qa_q <= qa_q + 7'd1;
        4'd9: if (rd >= 28'(DIV_3125)) qd_q <= qd_q + 16'd1;
        default: ;
      endcase
    end
  end

  // ---------------- result word
  logic        dfwd, drev, sright, sleft, tmo;
  logic [1:0]  dir_cls, str_cls;
  logic [55:0] word;
  logic [55:0] out_q;
  logic        ovalid_q;

  always_comb begin
    dfwd    = ht_q > DEADBAND;
    drev    = ht_q < -DEADBAND;
    sright  = hs_q > DEADBAND;
    sleft   = hs_q < -DEADBAND;
    dir_cls = (ht_q > DIR_LIMIT) ? 2'd1 : ((ht_q < -DIR_LIMIT) ? 2'd2 : 2'd0);
    str_cls = (hs_q > STEER_LIMIT) ? 2'd1 : ((hs_q < -STEER_LIMIT) ? 2'd2 : 2'd0);
    tmo     = !armed_q || (el_q > cfg.timeout_ticks);
    word    = {7'd0, fired_q, tmo, qa_q, str_cls, dir_cls,
               (sright || sleft) ? qs_q : 16'd0, sleft, sright,
               (dfwd || drev) ? qd_q : 16'd0, drev, dfwd};
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  // ---------------- checks
  a_fired_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q |-> !armed_q)
    else $error("watchdog flag set while armed");

  a_fired_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q |-> (ht_q == '0 && hs_q == '0 && hsp_q == '0))
    else $error("held command survives watchdog stop");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsp_q <= SPEED_MAX && ht_q <= CMD_MAX && ht_q >= CMD_MIN
    && hs_q <= CMD_MAX && hs_q >= CMD_MIN)
    else $error("held command out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CALC && step_q == 4'd0)
    else $error("accepted word did not start the sequence");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result word loaded over a pending one");

endmodule
